// File: design/nearest_scaler_pixel_convert_assert.svh
// Assertion helpers used by the scaler controller.
`ifndef NEAREST_SCALER_PIXEL_CONVERT_ASSERT_SVH
`define NEAREST_SCALER_PIXEL_CONVERT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NSPC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nspc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define NSPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nspc assertion failed");

`endif

// File: design/nspc_pkg.sv
package nspc_pkg;

    // Default geometry of the output screen and size of the source store.
    localparam int DEF_OUT_WIDTH  = 1920;
    localparam int DEF_OUT_HEIGHT = 1080;
    localparam int DEF_SRC_PIXELS = 131072;

    // Fixed field widths.
    localparam int DIM_W      = 12;
    localparam int COORD_W    = 11;
    localparam int INDEX_W    = 17;
    localparam int PIXEL_W    = 16;
    localparam int RGB_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [DIM_W-1:0] RST_SRC_WIDTH  = 12'd320;
    localparam logic [DIM_W-1:0] RST_SRC_HEIGHT = 12'd240;

    // Opcodes and pixel formats.
    localparam logic OP_WRITE     = 1'b0;
    localparam logic OP_READ      = 1'b1;
    localparam logic FMT_RGB565   = 1'b0;
    localparam logic FMT_RGBX4444 = 1'b1;

    // Step commands from the controller to the datapath.
    typedef struct packed {
        logic item_load;
        logic prod_en;
        logic recip_en;
        logic rem_en;
        logic quot_en;
        logic index_en;
        logic fetch_en;
        logic out_load;
    } cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic opcode_read;
    } status_t;

endpackage

// File: design/nspc_ram.sv
module nspc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/nspc_div.sv
// Division of a product by a constant: a reciprocal multiply gives an
// estimate that is exact or one low, and one remainder compare fixes it.
module nspc_div #(
    parameter int DIVISOR = 1920,
    parameter int PROD_W  = 23,
    localparam int QUOT_W = PROD_W - $clog2(DIVISOR + 1) + 1
) (
    input  logic               clk,
    input  nspc_pkg::cmd_t     cmd,
    input  logic [PROD_W-1:0]  prod,
    output logic [QUOT_W-1:0]  quot
);

    localparam int DIV_W   = $clog2(DIVISOR + 1);
    localparam int SHIFT   = PROD_W + DIV_W;
    localparam int RECIP_W = PROD_W + 2;
    localparam int MUL_W   = PROD_W + RECIP_W;
    localparam int REM_W   = $clog2(2 * DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SHIFT) / DIVISOR);
    localparam logic [PROD_W-1:0]  DIVISOR_P = PROD_W'(DIVISOR);
    localparam logic [REM_W-1:0]   DIVISOR_R = REM_W'(DIVISOR);

    logic [MUL_W-1:0]  scaled;
    logic [PROD_W-1:0] diff;
    logic [QUOT_W-1:0] est_reg;
    logic [QUOT_W-1:0] est_next;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [QUOT_W-1:0] quot_reg;
    logic [QUOT_W-1:0] quot_next;

    assign scaled    = MUL_W'(prod) * MUL_W'(RECIP);
    assign est_next  = QUOT_W'(scaled >> SHIFT);
    // The estimate never exceeds the true quotient, so this stays below twice the divisor.
    assign diff      = prod - PROD_W'(est_reg) * DIVISOR_P;
    assign rem_next  = REM_W'(diff);
    assign quot_next = est_reg + QUOT_W'(rem_reg >= DIVISOR_R);

    always_ff @(posedge clk)
    begin
        if (cmd.recip_en)
        begin
            est_reg <= est_next;
        end
        if (cmd.rem_en)
        begin
            rem_reg <= rem_next;
        end
        if (cmd.quot_en)
        begin
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

// File: design/nspc_ctrl.sv
`include "nearest_scaler_pixel_convert_assert.svh"

module nspc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  nspc_pkg::status_t status,
    output nspc_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_RECIP,
        ST_REM,
        ST_QUOT,
        ST_INDEX,
        ST_FETCH,
        ST_DATA
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.item_load = 1'b1;
                    // Writes finish in the accepting cycle; reads start the sequence.
                    if (status.opcode_read)
                    begin
                        state_next = ST_PROD;
                    end
                end
            end
            ST_PROD:
            begin
                cmd.prod_en = 1'b1;
                state_next  = ST_RECIP;
            end
            ST_RECIP:
            begin
                cmd.recip_en = 1'b1;
                state_next   = ST_REM;
            end
            ST_REM:
            begin
                cmd.rem_en = 1'b1;
                state_next = ST_QUOT;
            end
            ST_QUOT:
            begin
                cmd.quot_en = 1'b1;
                state_next  = ST_INDEX;
            end
            ST_INDEX:
            begin
                cmd.index_en = 1'b1;
                state_next   = ST_FETCH;
            end
            ST_FETCH:
            begin
                cmd.fetch_en = 1'b1;
                state_next   = ST_DATA;
            end
            ST_DATA:
            begin
                // The result waits here until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    `NSPC_ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_reg || out_ready)
    `NSPC_ASSERT_NEXT(a_read_busy, clk, rst_n, in_valid && in_ready && status.opcode_read, !in_ready)
    `NSPC_ASSERT_NEXT(a_fetch_then_data, clk, rst_n, cmd.fetch_en, state_reg == ST_DATA)
    `NSPC_ASSERT_SAME(a_valid_from_load, clk, rst_n, $rose(out_valid_reg), $past(cmd.out_load))

endmodule

// File: design/nspc_dp.sv
module nspc_dp #(
    parameter int OUT_WIDTH  = nspc_pkg::DEF_OUT_WIDTH,
    parameter int OUT_HEIGHT = nspc_pkg::DEF_OUT_HEIGHT,
    parameter int SRC_PIXELS = nspc_pkg::DEF_SRC_PIXELS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  nspc_pkg::cmd_t                    cmd,
    output nspc_pkg::status_t                 status,
    input  logic                              opcode,
    input  logic [nspc_pkg::INDEX_W-1:0]      src_index,
    input  logic [nspc_pkg::PIXEL_W-1:0]      src_pixel,
    input  logic [nspc_pkg::COORD_W-1:0]      out_x,
    input  logic [nspc_pkg::COORD_W-1:0]      out_y,
    output logic [nspc_pkg::RGB_W-1:0]        pixel_out,
    output logic                              out_of_range,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [nspc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nspc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int ADDR_W = $clog2(SRC_PIXELS);
    localparam int PROD_W = nspc_pkg::DIM_W + nspc_pkg::COORD_W;
    localparam int QX_W   = PROD_W - $clog2(OUT_WIDTH + 1) + 1;
    localparam int QY_W   = PROD_W - $clog2(OUT_HEIGHT + 1) + 1;
    localparam int IDX_W  = nspc_pkg::DIM_W + QY_W + 1;

    function automatic logic [nspc_pkg::RGB_W-1:0] expand(
        input logic [nspc_pkg::PIXEL_W-1:0] p,
        input logic                         fmt
    );
        logic [nspc_pkg::RGB_W-1:0] w;
        begin
            w = '0;
            if (fmt == nspc_pkg::FMT_RGBX4444)
            begin
                w[23:20] = p[15:12];
                w[15:12] = p[7:4];
                w[7:4]   = p[11:8];
            end
            else
            begin
                w[23:19] = p[15:11];
                w[15:11] = p[4:0];
                w[7:2]   = p[10:5];
            end
            return w;
        end
    endfunction

    logic [nspc_pkg::DIM_W-1:0]   width_reg;
    logic [nspc_pkg::DIM_W-1:0]   height_reg;
    logic                         format_reg;
    logic [nspc_pkg::COORD_W-1:0] x_reg;
    logic [nspc_pkg::COORD_W-1:0] y_reg;
    logic [PROD_W-1:0]            prod_x_reg;
    logic [PROD_W-1:0]            prod_y_reg;
    logic [QX_W-1:0]              sx;
    logic [QY_W-1:0]              sy;
    logic [IDX_W-1:0]             idx_reg;
    logic                         oor_reg;
    logic [nspc_pkg::RGB_W-1:0]   pixel_reg;
    logic                         flag_reg;
    logic                         ram_we;
    logic [nspc_pkg::PIXEL_W-1:0] ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= nspc_pkg::RST_SRC_WIDTH;
            height_reg <= nspc_pkg::RST_SRC_HEIGHT;
            format_reg <= nspc_pkg::FMT_RGB565;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                nspc_pkg::REG_SRC_WIDTH:    width_reg  <= cfg_data;
                nspc_pkg::REG_SRC_HEIGHT:   height_reg <= cfg_data;
                nspc_pkg::REG_PIXEL_FORMAT: format_reg <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            x_reg <= out_x;
            y_reg <= out_y;
        end
        if (cmd.prod_en)
        begin
            prod_x_reg <= PROD_W'(width_reg) * PROD_W'(x_reg);
            prod_y_reg <= PROD_W'(height_reg) * PROD_W'(y_reg);
        end
        if (cmd.index_en)
        begin
            idx_reg <= IDX_W'(width_reg) * IDX_W'(sy) + IDX_W'(sx);
        end
        if (cmd.fetch_en)
        begin
            oor_reg <= 32'(idx_reg) >= 32'(SRC_PIXELS);
        end
        if (cmd.out_load)
        begin
            pixel_reg <= oor_reg ? '0 : expand(ram_rdata, format_reg);
            flag_reg  <= oor_reg;
        end
    end

    nspc_div #(
        .DIVISOR (OUT_WIDTH),
        .PROD_W  (PROD_W)
    ) u_div_x (
        .clk  (clk),
        .cmd  (cmd),
        .prod (prod_x_reg),
        .quot (sx)
    );

    nspc_div #(
        .DIVISOR (OUT_HEIGHT),
        .PROD_W  (PROD_W)
    ) u_div_y (
        .clk  (clk),
        .cmd  (cmd),
        .prod (prod_y_reg),
        .quot (sy)
    );

    // Writes beyond the store are dropped.
    assign ram_we = cmd.item_load && (opcode == nspc_pkg::OP_WRITE)
                    && (32'(src_index) < 32'(SRC_PIXELS));

    nspc_ram #(
        .WIDTH (nspc_pkg::PIXEL_W),
        .DEPTH (SRC_PIXELS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(src_index)),
        .wdata (src_pixel),
        .re    (cmd.fetch_en),
        .raddr (ADDR_W'(idx_reg)),
        .rdata (ram_rdata)
    );

    assign status.opcode_read = (opcode == nspc_pkg::OP_READ);
    assign cfg_ready          = 1'b1;
    assign pixel_out          = pixel_reg;
    assign out_of_range       = flag_reg;

endmodule

// File: design/nearest_scaler_pixel_convert.sv
// Nearest-neighbour scaler over a 16-bit source frame store. A write word
// (opcode 0) stores src_pixel at src_index when accepted; while no read runs,
// writes stream at one per clock; indexes beyond the store are dropped. A read
// word (opcode 1) maps screen pixel (out_x, out_y) to source pixel
// (src_width*out_x/OUT_WIDTH, src_height*out_y/OUT_HEIGHT), fetches it and
// returns it expanded to 24 bits (red, blue, green bytes) in RGB565 or
// RGBX4444 form, or zero with out_of_range set when the index falls beyond
// the store. A read holds off the input while the controller steps
// through the coordinate products, the reciprocal-multiply division by the
// screen size, its remainder correction, the linear index, and the store read
// port, one step per cycle; the next word is taken as soon as the result sits
// in the output register, which holds it until the consumer takes it.
// Configuration writes are taken at any time but are meant for idle periods;
// the store needs no clearing after reset.
module nearest_scaler_pixel_convert #(
    parameter int OUT_WIDTH  = nspc_pkg::DEF_OUT_WIDTH,
    parameter int OUT_HEIGHT = nspc_pkg::DEF_OUT_HEIGHT,
    parameter int SRC_PIXELS = nspc_pkg::DEF_SRC_PIXELS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            opcode,
    input  logic [nspc_pkg::INDEX_W-1:0]    src_index,
    input  logic [nspc_pkg::PIXEL_W-1:0]    src_pixel,
    input  logic [nspc_pkg::COORD_W-1:0]    out_x,
    input  logic [nspc_pkg::COORD_W-1:0]    out_y,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [nspc_pkg::RGB_W-1:0]      pixel_out,
    output logic                            out_of_range,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [nspc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nspc_pkg::CFG_DATA_W-1:0] cfg_data
);

    nspc_pkg::cmd_t    cmd;
    nspc_pkg::status_t status;

    nspc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    nspc_dp #(
        .OUT_WIDTH  (OUT_WIDTH),
        .OUT_HEIGHT (OUT_HEIGHT),
        .SRC_PIXELS (SRC_PIXELS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .opcode       (opcode),
        .src_index    (src_index),
        .src_pixel    (src_pixel),
        .out_x        (out_x),
        .out_y        (out_y),
        .pixel_out    (pixel_out),
        .out_of_range (out_of_range),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

endmodule

// File: sim/nearest_scaler_pixel_convert_tb.sv
`timescale 1ns / 100ps

module nearest_scaler_pixel_convert_tb;

    localparam int OUT_W        = nspc_pkg::DEF_OUT_WIDTH;
    localparam int OUT_H        = nspc_pkg::DEF_OUT_HEIGHT;
    localparam int STORE_DEPTH  = nspc_pkg::DEF_SRC_PIXELS;
    localparam int COORD_MAX    = (1 << nspc_pkg::COORD_W) - 1;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 24;
    localparam int BLOCK_WORDS  = 250;

    // No register sits at this index; a write to it must change nothing.
    localparam logic [nspc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef logic [nspc_pkg::COORD_W-1:0] coord_t;
    typedef logic [nspc_pkg::PIXEL_W-1:0] pix_t;
    typedef logic [nspc_pkg::INDEX_W-1:0] index_t;

    typedef struct packed {
        logic                         op;
        logic [nspc_pkg::INDEX_W-1:0] idx;
        logic [nspc_pkg::PIXEL_W-1:0] pix;
        logic [nspc_pkg::COORD_W-1:0] x;
        logic [nspc_pkg::COORD_W-1:0] y;
    } word_t;

    typedef struct packed {
        logic [nspc_pkg::RGB_W-1:0] rgb;
        logic                       oor;
    } pixel_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic                            opcode = nspc_pkg::OP_WRITE;
    logic [nspc_pkg::INDEX_W-1:0]    src_index = '0;
    logic [nspc_pkg::PIXEL_W-1:0]    src_pixel = '0;
    logic [nspc_pkg::COORD_W-1:0]    out_x = '0;
    logic [nspc_pkg::COORD_W-1:0]    out_y = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [nspc_pkg::RGB_W-1:0]      pixel_out;
    logic                            out_of_range;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [nspc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [nspc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Words waiting for the driver, and pixels the block still owes us.
    word_t         pending_words[$];
    pixel_result_t expected_pixels[$];

    // Frame contents and registers as the block should see them on acceptance.
    logic [nspc_pkg::PIXEL_W-1:0] frame_copy[STORE_DEPTH];
    logic [nspc_pkg::DIM_W-1:0]   shadow_width  = nspc_pkg::RST_SRC_WIDTH;
    logic [nspc_pkg::DIM_W-1:0]   shadow_height = nspc_pkg::RST_SRC_HEIGHT;
    logic                         shadow_format = nspc_pkg::FMT_RGB565;

    // What the stimulus side has planned so far, used to avoid unwritten reads.
    bit                           frame_written[STORE_DEPTH];
    logic [nspc_pkg::DIM_W-1:0]   plan_width  = nspc_pkg::RST_SRC_WIDTH;
    logic [nspc_pkg::DIM_W-1:0]   plan_height = nspc_pkg::RST_SRC_HEIGHT;
    logic                         plan_format = nspc_pkg::FMT_RGB565;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int words_queued = 0;
    int reads_queued = 0;
    int writes_queued = 0;
    int pixels_checked = 0;
    int oor_seen = 0;
    int reg_writes = 0;
    int cycles_run = 0;

    nearest_scaler_pixel_convert u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .src_index    (src_index),
        .src_pixel    (src_pixel),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_out    (pixel_out),
        .out_of_range (out_of_range),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic longint unsigned scaled_index(
        input logic [nspc_pkg::DIM_W-1:0]   w,
        input logic [nspc_pkg::DIM_W-1:0]   h,
        input logic [nspc_pkg::COORD_W-1:0] x,
        input logic [nspc_pkg::COORD_W-1:0] y
    );
        longint unsigned lw;
        longint unsigned sx;
        longint unsigned sy;
        lw = 64'(w);
        sx = (lw * 64'(x)) / 64'(OUT_W);
        sy = (64'(h) * 64'(y)) / 64'(OUT_H);
        return lw * sy + sx;
    endfunction

    function automatic logic [nspc_pkg::RGB_W-1:0] expand_to_rgb24(
        input logic                         fmt,
        input logic [nspc_pkg::PIXEL_W-1:0] p
    );
        if (fmt == nspc_pkg::FMT_RGBX4444)
            return {p[15:12], 4'b0, p[7:4], 4'b0, p[11:8], 4'b0};
        return {p[15:11], 3'b0, p[4:0], 3'b0, p[10:5], 2'b0};
    endfunction

    // Updates the frame copy for a write word, or queues the pixel a read owes.
    task automatic predict_pixel_for_word(input word_t w);
        longint unsigned li;
        pixel_result_t   r;
        if (w.op == nspc_pkg::OP_WRITE)
        begin
            if (32'(w.idx) < STORE_DEPTH)
                frame_copy[w.idx] = w.pix;
        end
        else
        begin
            li = scaled_index(shadow_width, shadow_height, w.x, w.y);
            if (li >= 64'(STORE_DEPTH))
            begin
                r.rgb = '0;
                r.oor = 1'b1;
            end
            else
            begin
                r.rgb = expand_to_rgb24(shadow_format,
                                        frame_copy[li[nspc_pkg::INDEX_W-1:0]]);
                r.oor = 1'b0;
            end
            expected_pixels.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        word_t w;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            opcode    <= nspc_pkg::OP_WRITE;
            src_index <= '0;
            src_pixel <= '0;
            out_x     <= '0;
            out_y     <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_pixel_for_word(word_t'({opcode, src_index, src_pixel, out_x, out_y}));
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    w = pending_words.pop_front();
                    in_valid  <= 1'b1;
                    opcode    <= w.op;
                    src_index <= w.idx;
                    src_pixel <= w.pix;
                    out_x     <= w.x;
                    out_y     <= w.y;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                pixels_checked++;
                if (out_of_range === 1'b1)
                    oor_seen++;
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch($sformatf("pixel %06h arrived with none expected",
                                              pixel_out));
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel_out !== want.rgb)
                        report_mismatch($sformatf("pixel_out %06h, expected %06h",
                                                  pixel_out, want.rgb));
                    if (out_of_range !== want.oor)
                        report_mismatch($sformatf("out_of_range %b, expected %b",
                                                  out_of_range, want.oor));
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // The shadow registers follow the write channel exactly as the block sees it.
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                nspc_pkg::REG_SRC_WIDTH:    shadow_width  <= cfg_data[nspc_pkg::DIM_W-1:0];
                nspc_pkg::REG_SRC_HEIGHT:   shadow_height <= cfg_data[nspc_pkg::DIM_W-1:0];
                nspc_pkg::REG_PIXEL_FORMAT: shadow_format <= cfg_data[0];
                default: ;
            endcase
        end
    end

    initial
    begin
        for (cycles_run = 0; cycles_run < CYCLE_LIMIT; cycles_run++)
            @(posedge clk);
        $display("run stopped after %0d cycles with %0d pixels still owed",
                 cycles_run, expected_pixels.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic queue_write(input logic [nspc_pkg::INDEX_W-1:0] ix,
                               input logic [nspc_pkg::PIXEL_W-1:0] p);
        word_t w;
        w.op  = nspc_pkg::OP_WRITE;
        w.idx = ix;
        w.pix = p;
        w.x   = coord_t'($urandom);
        w.y   = coord_t'($urandom);
        pending_words.push_back(w);
        frame_written[ix] = 1'b1;
        words_queued++;
        writes_queued++;
    endtask

    // A read that lands on a never-written entry gets a write of its own first.
    task automatic queue_read(input logic [nspc_pkg::COORD_W-1:0] x,
                              input logic [nspc_pkg::COORD_W-1:0] y);
        word_t           w;
        longint unsigned li;
        li = scaled_index(plan_width, plan_height, x, y);
        if (li < 64'(STORE_DEPTH) && !frame_written[li[nspc_pkg::INDEX_W-1:0]])
            queue_write(li[nspc_pkg::INDEX_W-1:0], pix_t'($urandom));
        w.op  = nspc_pkg::OP_READ;
        w.idx = index_t'($urandom);
        w.pix = pix_t'($urandom);
        w.x   = x;
        w.y   = y;
        pending_words.push_back(w);
        words_queued++;
        reads_queued++;
    endtask

    task automatic wait_for_results();
        while (pending_words.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    // A write word leaves nothing to wait for, so allow for a read still in flight.
    task automatic wait_until_drained();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [nspc_pkg::CFG_IDX_W-1:0]  ri,
                                  input logic [nspc_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (ri)
            nspc_pkg::REG_SRC_WIDTH:    plan_width  = val[nspc_pkg::DIM_W-1:0];
            nspc_pkg::REG_SRC_HEIGHT:   plan_height = val[nspc_pkg::DIM_W-1:0];
            nspc_pkg::REG_PIXEL_FORMAT: plan_format = val[0];
            default: ;
        endcase
    endtask

    function automatic logic [nspc_pkg::COORD_W-1:0] pick_row();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return coord_t'($urandom_range(0, OUT_H - 1));
        if (pick < 80)
            return coord_t'($urandom_range(0, 40));
        return coord_t'($urandom_range(0, COORD_MAX));
    endfunction

    function automatic logic [nspc_pkg::COORD_W-1:0] pick_col();
        if ($urandom_range(0, 99) < 70)
            return coord_t'($urandom_range(0, OUT_W - 1));
        return coord_t'($urandom_range(0, COORD_MAX));
    endfunction

    // Mostly scan runs along a row and single reads, with stray writes as noise.
    task automatic run_random_block(input logic [nspc_pkg::DIM_W-1:0] w,
                                    input logic [nspc_pkg::DIM_W-1:0] h,
                                    input logic fmt, input bit hold_midway);
        int                           goal;
        int                           kind;
        int                           run_len;
        logic [nspc_pkg::COORD_W-1:0] x0;
        logic [nspc_pkg::COORD_W-1:0] y0;
        wait_until_drained();
        write_register(nspc_pkg::REG_SRC_WIDTH, w);
        write_register(nspc_pkg::REG_SRC_HEIGHT, h);
        write_register(nspc_pkg::REG_PIXEL_FORMAT, {{(nspc_pkg::CFG_DATA_W-1){1'b0}}, fmt});
        goal = words_queued + BLOCK_WORDS;
        while (words_queued < goal)
        begin
            if (hold_midway && words_queued >= goal - BLOCK_WORDS / 2)
            begin
                hold_midway = 1'b0;
                wait_for_results();
            end
            kind = $urandom_range(0, 99);
            if (kind < 15)
            begin
                queue_write(index_t'($urandom), pix_t'($urandom));
            end
            else if (kind < 45)
            begin
                run_len = $urandom_range(1, 16);
                y0 = pick_row();
                x0 = coord_t'($urandom_range(0, COORD_MAX + 1 - run_len));
                for (int k = 0; k < run_len; k++)
                    queue_read(coord_t'(x0 + k), y0);
            end
            else
            begin
                queue_read(pick_col(), pick_row());
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 29;
        recv_idle_pct = 77;

        // All RGB565 channels at full scale, then each channel alone, then nothing.
        queue_write('0, 16'hFFFF);
        queue_read('0, '0);
        queue_write('0, 16'hF800);
        queue_read('0, '0);
        queue_write('0, 16'h07E0);
        queue_read('0, '0);
        queue_write('0, 16'h001F);
        queue_read('0, '0);
        queue_write('0, 16'h0000);
        queue_read('0, '0);
        queue_write('1, 16'hFFFF);
        // Last screen pixel, then coordinates past the screen edge.
        queue_read(coord_t'(OUT_W - 1), coord_t'(OUT_H - 1));
        queue_read(coord_t'(COORD_MAX), coord_t'(COORD_MAX));
        queue_read(coord_t'(COORD_MAX), '0);

        wait_until_drained();
        write_register(nspc_pkg::REG_PIXEL_FORMAT,
                       {{(nspc_pkg::CFG_DATA_W-1){1'b0}}, nspc_pkg::FMT_RGBX4444});
        queue_write('0, 16'hF000);
        queue_read('0, '0);
        queue_write('0, 16'h0F00);
        queue_read('0, '0);
        queue_write('0, 16'h00F0);
        queue_read('0, '0);
        queue_write('0, 16'h000F);
        queue_read('0, '0);

        wait_until_drained();
        write_register(REG_UNUSED, '1);
        queue_read('0, '0);

        // A zero-sized frame folds every coordinate onto the first entry.
        wait_until_drained();
        write_register(nspc_pkg::REG_SRC_WIDTH, '0);
        write_register(nspc_pkg::REG_SRC_HEIGHT, '0);
        queue_read(coord_t'(COORD_MAX), coord_t'(COORD_MAX));

        run_random_block(12'd320, 12'd240, nspc_pkg::FMT_RGB565, 1'b0);
        run_random_block(12'd1, 12'd1, nspc_pkg::FMT_RGBX4444, 1'b0);
        send_idle_pct = 77;
        recv_idle_pct = 29;
        run_random_block(12'd2048, 12'd2048, nspc_pkg::FMT_RGB565, 1'b0);
        run_random_block(12'd4095, 12'd4095, nspc_pkg::FMT_RGBX4444, 1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_block(12'd1000, 12'd0, nspc_pkg::FMT_RGB565, 1'b0);
        run_random_block(12'd640, 12'd480, nspc_pkg::FMT_RGBX4444, 1'b1);

        wait_until_drained();
        if (expected_pixels.size() != 0)
            report_mismatch($sformatf("%0d pixels never arrived", expected_pixels.size()));

        $display("sent %0d words (%0d reads, %0d writes) and %0d register writes in %0d cycles",
                 words_queued, reads_queued, writes_queued, reg_writes, cycles_run);
        $display("checked %0d pixels, %0d beyond the store, over both formats and sizes 0-4095",
                 pixels_checked, oor_seen);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/nspc_pkg.sv
design/nspc_ram.sv
design/nspc_div.sv
design/nspc_ctrl.sv
design/nspc_dp.sv
design/nearest_scaler_pixel_convert.sv
sim/nearest_scaler_pixel_convert_tb.sv
